// ===== rtl/core/lfse_pkg.sv =====
`timescale 1ns / 1ps
// Shared constants, codes and control types for the LIFO/FIFO stack engine.
package lfse_pkg;

  // Store geometry
  localparam int unsigned DEPTH   = 1024;
  localparam int unsigned ITEM_W  = 32;
  localparam int unsigned ADDR_W  = $clog2(DEPTH);
  localparam int unsigned PTR_W   = ADDR_W + 1;

  // Fixed field widths of the command port
  localparam int unsigned COUNT_W = 11;
  localparam int unsigned PEEK_W  = 10;

  // Common width for comparing pointers against counts and depths
  localparam int unsigned CMP_W   = (PTR_W > COUNT_W) ? PTR_W : COUNT_W;

  // Operation codes
  typedef enum logic [1:0] {
    FUNC_PUSH  = 2'd0,
    FUNC_POP   = 2'd1,
    FUNC_PEEK  = 2'd2,
    FUNC_CLEAR = 2'd3
  } func_e;

  // Result status codes
  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_FULL      = 2'd1,
    STAT_UNDERFLOW = 2'd2,
    STAT_BAD_COUNT = 2'd3
  } status_e;

  // Queue mode values
  localparam logic MODE_LIFO = 1'b0;
  localparam logic MODE_FIFO = 1'b1;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic latch;  // capture the incoming item
    logic exec;   // run the operation: pointers and memory access
  } ctrl_cmd_t;

endpackage

// ===== rtl/core/lfse_ctrl.sv =====
`timescale 1ns / 1ps
// Sequencing controller: accept, execute, respond.
module lfse_ctrl
  import lfse_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      start_i,
  output logic      busy_o,
  output logic      done_o,
  output ctrl_cmd_t cmd_o
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_EXEC = 2'd1;
  localparam logic [1:0] ST_RESP = 2'd2;

  logic [1:0] state_q, state_d;

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (start_i) state_d = ST_EXEC;
      end
      ST_EXEC: state_d = ST_RESP;
      ST_RESP: state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Outputs
  assign busy_o       = (state_q != ST_IDLE);
  assign done_o       = (state_q == ST_RESP);
  assign cmd_o.latch  = (state_q == ST_IDLE) && start_i;
  assign cmd_o.exec   = (state_q == ST_EXEC);

endmodule

// ===== rtl/core/lfse_datapath.sv =====
`timescale 1ns / 1ps
// Datapath: item store, fill and read pointers, mode register, result registers.
module lfse_datapath
  import lfse_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  ctrl_cmd_t           cmd_i,
  input  logic [1:0]          func_i,
  input  logic [ITEM_W-1:0]   item_value_i,
  input  logic [COUNT_W-1:0]  pop_count_i,
  input  logic [PEEK_W-1:0]   peek_depth_i,
  input  logic                cfg_we_i,
  input  logic                cfg_data_i,
  output logic [ITEM_W-1:0]   item_out_o,
  output logic                store_empty_o,
  output logic [1:0]          status_o
);

  // Item store, no reset: entries are read only after being written
  logic [ITEM_W-1:0] mem [DEPTH];
  logic [ITEM_W-1:0] rdata_q;

  // Captured item
  func_e              func_q;
  logic [ITEM_W-1:0]  value_q;
  logic [COUNT_W-1:0] count_q;
  logic [PEEK_W-1:0]  depth_q;

  // Pointers and mode
  logic [PTR_W-1:0] fill_q, fill_d;
  logic [PTR_W-1:0] rdptr_q, rdptr_d;
  logic             mode_q;

  // Result registers
  status_e status_q, status_d;
  logic    empty_q, empty_d;
  logic    item_ok_q, item_ok_d;

  // Memory access controls
  logic              we;
  logic              re;
  logic [ADDR_W-1:0] raddr;

  // Widened operands for compares
  logic [CMP_W-1:0] fill_c;
  logic [CMP_W-1:0] rdptr_c;
  logic [CMP_W-1:0] count_c;
  logic [CMP_W-1:0] depth_c;
  logic [PTR_W-1:0] lifo_rem;
  logic [PTR_W-1:0] peek_pos;

  assign fill_c   = CMP_W'(fill_q);
  assign rdptr_c  = CMP_W'(rdptr_q);
  assign count_c  = CMP_W'(count_q);
  assign depth_c  = CMP_W'(depth_q);
  assign lifo_rem = fill_q - PTR_W'(count_q);
  assign peek_pos = fill_q - PTR_W'(depth_q) - PTR_W'(1);

  // Capture the item on accept
  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      func_q  <= func_e'(func_i);
      value_q <= item_value_i;
      count_q <= pop_count_i;
      depth_q <= peek_depth_i;
    end
  end

  // Operation decode
  always_comb begin
    fill_d    = fill_q;
    rdptr_d   = rdptr_q;
    status_d  = STAT_OK;
    item_ok_d = 1'b0;
    we        = 1'b0;
    re        = 1'b0;
    raddr     = fill_q[ADDR_W-1:0];
    unique case (func_q)
      FUNC_PUSH: begin
        if (fill_q == PTR_W'(DEPTH)) begin
          status_d = STAT_FULL;
        end else begin
          we     = 1'b1;
          fill_d = fill_q + PTR_W'(1);
        end
      end
      FUNC_POP: begin
        if (mode_q == MODE_LIFO) begin
          if (count_q == '0 || count_c > fill_c) begin
            status_d = STAT_UNDERFLOW;
          end else begin
            fill_d    = lifo_rem;
            re        = 1'b1;
            raddr     = lifo_rem[ADDR_W-1:0];
            item_ok_d = 1'b1;
          end
        end else if (count_q != COUNT_W'(1)) begin
          status_d = STAT_BAD_COUNT;
        end else if (rdptr_c >= fill_c) begin
          status_d = STAT_UNDERFLOW;
        end else begin
          re        = 1'b1;
          raddr     = rdptr_q[ADDR_W-1:0];
          rdptr_d   = rdptr_q + PTR_W'(1);
          item_ok_d = 1'b1;
        end
      end
      FUNC_PEEK: begin
        if (depth_c >= fill_c) begin
          status_d = STAT_UNDERFLOW;
        end else begin
          re        = 1'b1;
          raddr     = peek_pos[ADDR_W-1:0];
          item_ok_d = 1'b1;
        end
      end
      FUNC_CLEAR: begin
        fill_d  = '0;
        rdptr_d = '0;
      end
      default: begin
        fill_d  = fill_q;
      end
    endcase
    // Empty flag after the operation, by mode
    if (mode_q == MODE_LIFO) begin
      empty_d = (fill_d == '0);
    end else begin
      empty_d = (rdptr_d >= fill_d);
    end
  end

  // Store port: one write or one read per operation
  always_ff @(posedge clk_i) begin
    if (cmd_i.exec && we) begin
      mem[fill_q[ADDR_W-1:0]] <= value_q;
    end
    if (cmd_i.exec && re) begin
      rdata_q <= mem[raddr];
    end
  end

  // Pointers, mode and result control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q    <= '0;
      rdptr_q   <= '0;
      mode_q    <= MODE_LIFO;
      status_q  <= STAT_OK;
      empty_q   <= 1'b1;
      item_ok_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        mode_q <= cfg_data_i;
      end
      if (cmd_i.exec) begin
        fill_q    <= fill_d;
        rdptr_q   <= rdptr_d;
        status_q  <= status_d;
        empty_q   <= empty_d;
        item_ok_q <= item_ok_d;
      end
    end
  end

  // Result fields
  assign item_out_o    = item_ok_q ? rdata_q : '0;
  assign store_empty_o = empty_q;
  assign status_o      = status_q;

endmodule

// ===== rtl/core/lifo_fifo_stack_engine.sv =====
`timescale 1ns / 1ps
// Top level of the LIFO/FIFO stack engine.
//
// Each item is accepted when start is high and busy is low; the next cycle
// updates the pointers and makes the one access to the single-port item
// store, and then the result stands on item_out_o, store_empty_o and status_o
// with done_o high for exactly one cycle. A new item can be accepted in the
// cycle after done_o. The result
// cannot be held off, so it must be taken while done_o is high. The queue mode
// register is written over the cfg channel, which is ready only while busy is
// low, so a mode change never lands under an item in flight. The item store
// has no reset: only entries below the fill pointer are ever read.
module lifo_fifo_stack_engine
  import lfse_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         func_i,
  input  logic [ITEM_W-1:0]  item_value_i,
  input  logic [COUNT_W-1:0] pop_count_i,
  input  logic [PEEK_W-1:0]  peek_depth_i,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic               cfg_data_i,
  output logic               done_o,
  output logic [ITEM_W-1:0]  item_out_o,
  output logic               store_empty_o,
  output logic [1:0]         status_o
);

  ctrl_cmd_t cmd;
  logic      cfg_we;

  // Mode register takes a write only while no item is in flight
  assign cfg_ready_o = !busy;
  assign cfg_we      = cfg_valid_i && cfg_ready_o;

  // Controller
  lfse_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .busy_o  (busy),
    .done_o  (done_o),
    .cmd_o   (cmd)
  );

  // Datapath
  lfse_datapath u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .func_i        (func_i),
    .item_value_i  (item_value_i),
    .pop_count_i   (pop_count_i),
    .peek_depth_i  (peek_depth_i),
    .cfg_we_i      (cfg_we),
    .cfg_data_i    (cfg_data_i),
    .item_out_o    (item_out_o),
    .store_empty_o (store_empty_o),
    .status_o      (status_o)
  );

endmodule

// ===== rtl/core/lfse_checker.sv =====
`timescale 1ns / 1ps
// Port-level checker for the stack engine, bound to the top level.
module lfse_checker
  import lfse_pkg::*;
(
  input logic              clk_i,
  input logic              rst_ni,
  input logic              start,
  input logic              busy,
  input logic              done_o,
  input logic [ITEM_W-1:0] item_out_o,
  input logic [1:0]        status_o
);

  // An accepted item is followed by its result strobe on done_o
  a_resp_timing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> ##1 done_o)
    else $error("result not delivered on time");

  // The result strobe lasts one cycle
  a_strobe_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("result strobe held");

  // No result without an item in flight
  a_done_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> busy)
    else $error("result while idle");

  // Failed operations return a zero item
  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && (status_o != STAT_OK) |-> item_out_o == '0)
    else $error("non-zero item on failed operation");

endmodule

bind lifo_fifo_stack_engine lfse_checker u_lfse_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .start      (start),
  .busy       (busy),
  .done_o     (done_o),
  .item_out_o (item_out_o),
  .status_o   (status_o)
);

// ===== bench/tb_lifo_fifo_stack_engine.sv =====
`timescale 1ns / 1ps
// Self-checking bench for the LIFO/FIFO stack engine: clocked driver, monitor, shadow stack.
module tb_lifo_fifo_stack_engine;
  import lfse_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned OPS_PER_PHASE = 50;
  localparam int unsigned PHASES = 8;

  // Kinds of entry in the backlog: a stack operation, a mode write, a hold until drained
  typedef enum logic [1:0] {
    ENTRY_OP    = 2'd0,
    ENTRY_CFG   = 2'd1,
    ENTRY_DRAIN = 2'd2
  } entry_kind_e;

  typedef struct {
    entry_kind_e        kind;
    func_e              func;
    logic [ITEM_W-1:0]  value;
    logic [COUNT_W-1:0] count;
    logic [PEEK_W-1:0]  depth;
    logic               mode;
    int unsigned        gap;
  } stack_cmd_t;

  typedef struct {
    logic [ITEM_W-1:0] item;
    logic              empty;
    status_e           status;
  } stack_result_t;

  logic               clk_i         = 1'b0;
  logic               rst_ni        = 1'b0;
  logic               start         = 1'b0;
  logic               busy;
  logic [1:0]         func_i        = '0;
  logic [ITEM_W-1:0]  item_value_i  = '0;
  logic [COUNT_W-1:0] pop_count_i   = '0;
  logic [PEEK_W-1:0]  peek_depth_i  = '0;
  logic               cfg_valid_i   = 1'b0;
  logic               cfg_ready_o;
  logic               cfg_data_i    = 1'b0;
  logic               done_o;
  logic [ITEM_W-1:0]  item_out_o;
  logic               store_empty_o;
  logic [1:0]         status_o;

  lifo_fifo_stack_engine i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .func_i        (func_i),
    .item_value_i  (item_value_i),
    .pop_count_i   (pop_count_i),
    .peek_depth_i  (peek_depth_i),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i),
    .done_o        (done_o),
    .item_out_o    (item_out_o),
    .store_empty_o (store_empty_o),
    .status_o      (status_o)
  );

  always begin
    clk_i = 1'b1;
    #2;
    clk_i = 1'b0;
    #2;
  end

  // Shadow of the engine state
  logic [ITEM_W-1:0] shadow_store [DEPTH];
  logic [PTR_W-1:0]  fill_ptr = '0;
  logic [PTR_W-1:0]  rd_ptr   = '0;
  logic              q_mode   = MODE_LIFO;

  stack_cmd_t    cmd_backlog[$];
  stack_result_t expected_results[int];

  int unsigned issued_count  = 0;  // driver's own tally, blocking
  int unsigned ops_accepted  = 0;  // mirrored for the monitor
  int unsigned results_seen  = 0;
  int unsigned fail_count    = 0;
  int unsigned cycle_count   = 0;
  bit          stim_done     = 1'b0;
  bit          quiet_phase   = 1'b0;

  // Applies one operation to the shadow stack and returns what the engine should answer
  function automatic stack_result_t predict_stack_result(input stack_cmd_t op);
    stack_result_t r;
    r.item   = '0;
    r.status = STAT_OK;
    case (op.func)
      FUNC_PUSH: begin
        if (fill_ptr >= PTR_W'(DEPTH)) begin
          r.status = STAT_FULL;
        end else begin
          shadow_store[fill_ptr[ADDR_W-1:0]] = op.value;
          fill_ptr = fill_ptr + 1'b1;
        end
      end
      FUNC_POP: begin
        if (q_mode == MODE_LIFO) begin
          if (op.count == '0 || op.count > fill_ptr) begin
            r.status = STAT_UNDERFLOW;
          end else begin
            fill_ptr = fill_ptr - op.count;
            r.item   = shadow_store[fill_ptr[ADDR_W-1:0]];
          end
        end else if (op.count != COUNT_W'(1)) begin
          r.status = STAT_BAD_COUNT;
        end else if (rd_ptr >= fill_ptr) begin
          r.status = STAT_UNDERFLOW;
        end else begin
          r.item = shadow_store[rd_ptr[ADDR_W-1:0]];
          rd_ptr = rd_ptr + 1'b1;
        end
      end
      FUNC_PEEK: begin
        if (PTR_W'(op.depth) >= fill_ptr) begin
          r.status = STAT_UNDERFLOW;
        end else begin
          r.item = shadow_store[ADDR_W'(fill_ptr - op.depth - 1)];
        end
      end
      default: begin
        fill_ptr = '0;
        rd_ptr   = '0;
      end
    endcase
    r.empty = (q_mode == MODE_LIFO) ? (fill_ptr == '0) : (rd_ptr >= fill_ptr);
    return r;
  endfunction

  // Backlog builders
  task automatic add_op(input func_e f, input logic [ITEM_W-1:0] v,
                        input logic [COUNT_W-1:0] c, input logic [PEEK_W-1:0] d);
    stack_cmd_t e;
    e.kind  = ENTRY_OP;
    e.func  = f;
    e.value = v;
    e.count = c;
    e.depth = d;
    e.mode  = 1'b0;
    e.gap   = quiet_phase ? 0 : $urandom_range(0, 19);
    cmd_backlog.push_back(e);
  endtask

  task automatic add_ctrl(input entry_kind_e k, input logic m);
    stack_cmd_t e;
    e.kind  = k;
    e.func  = FUNC_CLEAR;
    e.value = '0;
    e.count = '0;
    e.depth = '0;
    e.mode  = m;
    e.gap   = quiet_phase ? 0 : $urandom_range(0, 19);
    cmd_backlog.push_back(e);
  endtask

  // Mostly well-formed traffic: small pops and shallow peeks, with the odd wild field
  task automatic add_random_op(input logic fifo);
    int unsigned        sel;
    logic [COUNT_W-1:0] c;
    logic [PEEK_W-1:0]  d;
    sel = $urandom_range(0, 99);
    c   = fifo ? COUNT_W'(1) : COUNT_W'($urandom_range(1, 3));
    d   = PEEK_W'($urandom_range(0, 7));
    if ($urandom_range(0, 9) == 0) c = COUNT_W'($urandom);
    if ($urandom_range(0, 9) == 0) d = PEEK_W'($urandom);
    if (sel < 45)      add_op(FUNC_PUSH, $urandom, COUNT_W'($urandom), PEEK_W'($urandom));
    else if (sel < 75) add_op(FUNC_POP, '0, c, '0);
    else if (sel < 96) add_op(FUNC_PEEK, '0, '0, d);
    else               add_op(FUNC_CLEAR, '0, '0, '0);
  endtask

  // Driver: feeds the backlog to the command and config ports
  always @(posedge clk_i) begin
    static stack_cmd_t  cur_op;
    static bit          have_cur = 1'b0;
    static int unsigned gap_left = 0;
    logic go_start;
    logic go_cfg;
    go_start = 1'b0;
    go_cfg   = cfg_valid_i;
    if (rst_ni) begin
      if (start && !busy) begin
        expected_results[issued_count] = predict_stack_result(cur_op);
        issued_count++;
        have_cur = 1'b0;
      end
      if (cfg_valid_i && cfg_ready_o) begin
        q_mode   = cfg_data_i;
        go_cfg   = 1'b0;
        have_cur = 1'b0;
      end
      if (!have_cur && cmd_backlog.size() > 0) begin
        cur_op   = cmd_backlog.pop_front();
        have_cur = 1'b1;
        gap_left = cur_op.gap;
      end
      if (have_cur) begin
        if (gap_left > 0) begin
          gap_left--;
        end else begin
          case (cur_op.kind)
            ENTRY_OP: go_start = 1'b1;
            ENTRY_CFG: begin
              // mode writes only once the engine has gone idle
              if (!go_cfg && issued_count == results_seen && !busy) go_cfg = 1'b1;
            end
            default: begin
              if (issued_count == results_seen) have_cur = 1'b0;
            end
          endcase
        end
      end
      ops_accepted <= issued_count;
      stim_done    <= !have_cur && cmd_backlog.size() == 0;
    end
    start       <= go_start;
    cfg_valid_i <= go_cfg;
    cfg_data_i  <= cur_op.mode;
    if (go_start) begin
      func_i       <= cur_op.func;
      item_value_i <= cur_op.value;
      pop_count_i  <= cur_op.count;
      peek_depth_i <= cur_op.depth;
    end
  end

  // Monitor: every strobed result against the oldest expectation
  always @(posedge clk_i) begin
    stack_result_t want;
    if (rst_ni && done_o) begin
      if (results_seen >= ops_accepted) begin
        $error("result with no item outstanding: item_out %h status %0d", item_out_o, status_o);
        fail_count++;
      end else begin
        want = expected_results[results_seen];
        expected_results.delete(results_seen);
        if (item_out_o !== want.item) begin
          $error("item_out mismatch: expected %h, got %h", want.item, item_out_o);
          fail_count++;
        end
        if (store_empty_o !== want.empty) begin
          $error("store_empty mismatch: expected %b, got %b", want.empty, store_empty_o);
          fail_count++;
        end
        if (status_o !== want.status) begin
          $error("status mismatch: expected %0d, got %0d", want.status, status_o);
          fail_count++;
        end
        results_seen <= results_seen + 1;
      end
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    // Empty stack, extremes of the fields, bad counts
    add_op(FUNC_POP, '0, COUNT_W'(1), '0);
    add_op(FUNC_PEEK, '0, '0, '0);
    add_op(FUNC_PUSH, '0, '0, '0);
    add_op(FUNC_PUSH, '1, '1, '1);
    add_op(FUNC_PUSH, 32'hA5A5_A5A5, '0, '0);
    add_op(FUNC_PUSH, 32'h5A5A_5A5A, '0, '0);
    add_op(FUNC_PEEK, '0, '0, '0);
    add_op(FUNC_PEEK, '0, '0, PEEK_W'(3));
    add_op(FUNC_PEEK, '0, '0, PEEK_W'(4));
    add_op(FUNC_PEEK, '0, '0, '1);
    add_op(FUNC_POP, '0, '0, '0);
    add_op(FUNC_POP, '0, '1, '0);
    add_op(FUNC_POP, '0, COUNT_W'(2), '0);
    add_op(FUNC_CLEAR, '1, '1, '1);
    add_op(FUNC_PUSH, 32'd1, '0, '0);
    add_op(FUNC_PUSH, 32'd2, '0, '0);
    // Queue mode: count checks, read pointer running up to the fill pointer
    add_ctrl(ENTRY_CFG, MODE_FIFO);
    add_op(FUNC_POP, '0, COUNT_W'(2), '0);
    add_op(FUNC_POP, '0, '0, '0);
    add_op(FUNC_POP, '0, COUNT_W'(1), '0);
    add_op(FUNC_POP, '0, COUNT_W'(1), '0);
    add_op(FUNC_POP, '0, COUNT_W'(1), '0);
    add_op(FUNC_PEEK, '0, '0, '0);
    add_ctrl(ENTRY_CFG, MODE_LIFO);
    add_op(FUNC_POP, '0, COUNT_W'(2), '0);
    add_ctrl(ENTRY_CFG, MODE_FIFO);
    add_op(FUNC_PUSH, 32'd7, '0, '0);
    add_op(FUNC_POP, '0, COUNT_W'(1), '0);
    add_op(FUNC_CLEAR, '0, '0, '0);
    add_ctrl(ENTRY_CFG, MODE_LIFO);

    // Fill to the brim, overflow, then the deepest peek and the largest pop
    quiet_phase = 1'b1;
    for (int i = 0; i < DEPTH; i++) add_op(FUNC_PUSH, $urandom, '0, '0);
    add_op(FUNC_PUSH, $urandom, '0, '0);
    add_op(FUNC_PEEK, '0, '0, '1);
    add_op(FUNC_PEEK, '0, '0, '0);
    add_op(FUNC_POP, '0, COUNT_W'(DEPTH), '0);
    add_op(FUNC_POP, '0, COUNT_W'(1), '0);

    // Random phases, each under a fresh mode and idling style
    for (int ph = 0; ph < PHASES; ph++) begin
      logic m;
      m = logic'($urandom_range(0, 1));
      quiet_phase = ($urandom_range(0, 3) == 0);
      add_ctrl(ENTRY_CFG, m);
      for (int k = 0; k < OPS_PER_PHASE; k++) begin
        if (k == OPS_PER_PHASE / 2 && (ph == 2 || $urandom_range(0, 2) == 0))
          add_ctrl(ENTRY_DRAIN, 1'b0);
        add_random_op(m);
      end
    end

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    do @(negedge clk_i); while (!(stim_done && results_seen == ops_accepted));
    repeat (10) @(negedge clk_i);
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
